@@ rtl/dclc_pkg.sv @@
package dclc_pkg;

    // Item kinds on the input channel.
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // Transport operation codes. Codes 6 and 7 carry no meaning and are ignored.
    localparam logic [2:0] OP_PLAY   = 3'd0;
    localparam logic [2:0] OP_RECORD = 3'd1;
    localparam logic [2:0] OP_FFWD   = 3'd2;
    localparam logic [2:0] OP_REWIND = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_STATUS = 3'd5;

    // Reply classes of a good received frame.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_NACK   = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    // Frame identifiers made of the first two received bytes.
    localparam logic [15:0] ID_STATUS = 16'h7920;
    localparam logic [15:0] ID_ACK    = 16'h1001;
    localparam logic [15:0] ID_NACK   = 16'h1112;

    // Outgoing command bytes.
    localparam logic [7:0] TRANSPORT_HDR = 8'h20;
    localparam logic [7:0] CODE_PLAY     = 8'h01;
    localparam logic [7:0] CODE_RECORD   = 8'h02;
    localparam logic [7:0] CODE_FFWD     = 8'h10;
    localparam logic [7:0] CODE_REWIND   = 8'h20;
    localparam logic [7:0] CODE_STOP     = 8'h00;
    localparam logic [7:0] STATUS_B0     = 8'h61;
    localparam logic [7:0] STATUS_B1     = 8'h20;
    localparam logic [7:0] STATUS_B2     = 8'h09;
    localparam logic [7:0] STATUS_SUM    = 8'(STATUS_B0 + STATUS_B1 + STATUS_B2);

    // Receive store: a frame always ends by byte 17.
    localparam int FRAME_LIMIT = 18;
    localparam int IDX_W       = 5;

    // Depth of the request queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
        logic [2:0] transport_op;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        frame_end;
        logic        checksum_bad;
        logic [1:0]  reply_kind;
        logic [7:0]  nack_code;
        logic [12:0] deck_flags;
        logic        status_updated;
        logic        tx_ready;
        logic        cmd_refused;
    } result_t;

    // One classified request, as handed from the front to the back.
    typedef struct packed {
        logic        is_send;
        logic [2:0]  op;
        logic        frame_end;
        logic        checksum_bad;
        logic [1:0]  reply_kind;
        logic [7:0]  nack_code;
        logic [12:0] deck_flags;
        logic        status_updated;
        logic        tx_ready;
        logic        cmd_refused;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/dclc_chan_if.sv @@
interface dclc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/dclc_front.sv @@
module dclc_front (
    input  logic               clk,
    input  logic               rst_n,
    dclc_chan_if.sink          item_ch,
    input  dclc_pkg::q_status_t q_st,
    output logic               push,
    output dclc_pkg::desc_t    desc
);
    import dclc_pkg::*;

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [IDX_W-1:0] checksum_index_reg, checksum_index_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [7:0]       last_status_sum_reg, last_status_sum_next;
    logic [12:0]      flag_bits_reg, flag_bits_next;
    logic             pending_reg, pending_next;
    logic [7:0]       hdr_reg [5];
    logic [7:0]       hdr_next [5];
    logic [7:0]       b10_reg, b10_next;

    item_t            item;
    logic             accept;
    logic [7:0]       v;
    logic [IDX_W-1:0] cks_idx_eff;
    logic [7:0]       sum_eff;
    logic [7:0]       b2_eff, b3_eff, b4_eff, b10_eff;
    logic [15:0]      frame_id;

    function automatic logic [12:0] decode_flags(input logic [7:0] b2, input logic [7:0] b3,
                                                 input logic [7:0] b4, input logic [7:0] b10);
        logic [12:0] f;
        f = {b10[4], b10[5], b4[1], b4[2], b4[4], b2[0], b2[5],
             b3[7], b3[5], b3[3], b3[2], b3[1], b3[0]};
        return f;
    endfunction

    assign item          = item_ch.payload;
    assign item_ch.ready = !q_st.full;
    assign accept        = item_ch.valid && !q_st.full;
    assign push          = accept;
    assign v             = item.rx_byte;

    // The byte being taken is written ahead of any read of the store.
    assign cks_idx_eff = (byte_index_reg == '0) ? (IDX_W'(v[3:0]) + IDX_W'(2))
                                                : checksum_index_reg;
    assign sum_eff  = (byte_index_reg == '0) ? 8'd0 : running_sum_reg;
    assign b2_eff   = (byte_index_reg == IDX_W'(2))  ? v : hdr_reg[2];
    assign b3_eff   = (byte_index_reg == IDX_W'(3))  ? v : hdr_reg[3];
    assign b4_eff   = (byte_index_reg == IDX_W'(4))  ? v : hdr_reg[4];
    assign b10_eff  = (byte_index_reg == IDX_W'(10)) ? v : b10_reg;
    assign frame_id = {hdr_reg[0], hdr_reg[1]};

    always_comb
    begin
        byte_index_next      = byte_index_reg;
        checksum_index_next  = checksum_index_reg;
        running_sum_next     = running_sum_reg;
        last_status_sum_next = last_status_sum_reg;
        flag_bits_next       = flag_bits_reg;
        pending_next         = pending_reg;
        for (int k = 0; k < 5; k++)
        begin
            hdr_next[k] = hdr_reg[k];
        end
        b10_next = b10_reg;

        desc            = '0;
        desc.op         = item.transport_op;
        desc.deck_flags = flag_bits_reg;
        desc.tx_ready   = !pending_reg;

        if (accept)
        begin
            if (item.cmd == CMD_RX)
            begin
                if (byte_index_reg >= IDX_W'(FRAME_LIMIT))
                begin
                    byte_index_next = '0;
                    pending_next    = 1'b0;
                end
                else
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        if (byte_index_reg == IDX_W'(k))
                        begin
                            hdr_next[k] = v;
                        end
                    end
                    if (byte_index_reg == IDX_W'(10))
                    begin
                        b10_next = v;
                    end
                    if (byte_index_reg == '0)
                    begin
                        checksum_index_next = cks_idx_eff;
                    end

                    if (byte_index_reg == cks_idx_eff)
                    begin
                        desc.frame_end = 1'b1;
                        if (sum_eff == v)
                        begin
                            if (frame_id == ID_STATUS)
                            begin
                                desc.reply_kind = KIND_STATUS;
                                if (sum_eff != last_status_sum_reg)
                                begin
                                    last_status_sum_next = sum_eff;
                                    flag_bits_next = decode_flags(b2_eff, b3_eff,
                                                                  b4_eff, b10_eff);
                                    desc.status_updated = 1'b1;
                                end
                            end
                            else if (frame_id == ID_ACK)
                            begin
                                desc.reply_kind = KIND_ACK;
                            end
                            else if (frame_id == ID_NACK)
                            begin
                                desc.reply_kind = KIND_NACK;
                                desc.nack_code  = b2_eff;
                            end
                            else
                            begin
                                desc.reply_kind = KIND_OTHER;
                            end
                        end
                        else
                        begin
                            desc.checksum_bad = 1'b1;
                        end
                        byte_index_next = '0;
                        pending_next    = 1'b0;
                    end
                    else
                    begin
                        running_sum_next = sum_eff + v;
                        byte_index_next  = byte_index_reg + IDX_W'(1);
                    end
                end
                desc.deck_flags = flag_bits_next;
                desc.tx_ready   = !pending_next;
            end
            else
            begin
                case (item.transport_op) inside
                    OP_STATUS:
                    begin
                        desc.is_send  = 1'b1;
                        desc.tx_ready = 1'b0;
                        pending_next  = 1'b1;
                    end
                    OP_PLAY, OP_RECORD, OP_FFWD, OP_REWIND, OP_STOP:
                    begin
                        if (pending_reg)
                        begin
                            desc.cmd_refused = 1'b1;
                        end
                        else
                        begin
                            desc.is_send  = 1'b1;
                            desc.tx_ready = 1'b0;
                            pending_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        desc.tx_ready = !pending_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg      <= '0;
            checksum_index_reg  <= '0;
            running_sum_reg     <= '0;
            last_status_sum_reg <= '0;
            flag_bits_reg       <= '0;
            pending_reg         <= 1'b0;
        end
        else
        begin
            byte_index_reg      <= byte_index_next;
            checksum_index_reg  <= checksum_index_next;
            running_sum_reg     <= running_sum_next;
            last_status_sum_reg <= last_status_sum_next;
            flag_bits_reg       <= flag_bits_next;
            pending_reg         <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 5; k++)
        begin
            hdr_reg[k] <= hdr_next[k];
        end
        b10_reg <= b10_next;
    end

endmodule

@@ rtl/dclc_queue.sv @@
module dclc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dclc_pkg::desc_t     push_desc,
    input  logic                pop,
    output dclc_pkg::desc_t     head_desc,
    output dclc_pkg::q_status_t q_st
);
    import dclc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    desc_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign q_st.full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign q_st.empty = (count_reg == '0);
    assign do_push    = push && !q_st.full;
    assign do_pop     = pop && !q_st.empty;
    assign head_desc  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

@@ rtl/dclc_back.sv @@
module dclc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  dclc_pkg::desc_t     head_desc,
    input  dclc_pkg::q_status_t q_st,
    output logic                pop,
    dclc_chan_if.source         result_ch
);
    import dclc_pkg::*;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       load;
    logic       last;
    result_t    res;

    function automatic logic [7:0] transport_code(input logic [2:0] op);
        logic [7:0] c;
        case (op)
            OP_PLAY:   c = CODE_PLAY;
            OP_RECORD: c = CODE_RECORD;
            OP_FFWD:   c = CODE_FFWD;
            OP_REWIND: c = CODE_REWIND;
            default:   c = CODE_STOP;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [2:0] op, input logic [1:0] idx);
        logic [7:0] b;
        if (op == OP_STATUS)
        begin
            case (idx)
                2'd0:    b = STATUS_B0;
                2'd1:    b = STATUS_B1;
                2'd2:    b = STATUS_B2;
                default: b = STATUS_SUM;
            endcase
        end
        else
        begin
            case (idx)
                2'd0:    b = TRANSPORT_HDR;
                2'd1:    b = transport_code(op);
                default: b = TRANSPORT_HDR + transport_code(op);
            endcase
        end
        return b;
    endfunction

    assign last = !head_desc.is_send ||
                  (cnt_reg == ((head_desc.op == OP_STATUS) ? 2'd3 : 2'd2));

    always_comb
    begin
        res                = '0;
        res.tx_valid       = head_desc.is_send;
        res.tx_byte        = head_desc.is_send ? frame_byte(head_desc.op, cnt_reg) : 8'd0;
        res.tx_last        = last;
        res.frame_end      = head_desc.frame_end;
        res.checksum_bad   = head_desc.checksum_bad;
        res.reply_kind     = head_desc.reply_kind;
        res.nack_code      = head_desc.nack_code;
        res.deck_flags     = head_desc.deck_flags;
        res.status_updated = head_desc.status_updated;
        res.tx_ready       = head_desc.tx_ready;
        res.cmd_refused    = head_desc.cmd_refused;
    end

    always_comb
    begin
        load           = !out_valid_reg || result_ch.ready;
        pop            = 1'b0;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = !q_st.empty;
            if (!q_st.empty)
            begin
                out_next = res;
                if (last)
                begin
                    pop      = 1'b1;
                    cnt_next = 2'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.payload = out_reg;

endmodule

@@ rtl/deck_control_link_client.sv @@
// Channel     Role    Payload                   Moves
// item_ch     sink    dclc_pkg::item_t          one received link byte or one send request
// result_ch   source  dclc_pkg::result_t        one result per cycle unless stalled, several per send
//
// A request is taken in the cycle it is offered whenever the two-entry queue between the
// front and the back has room, so received bytes flow at one request per cycle unless the
// result channel stalls. A received byte or a refused or ignored command gives one result;
// a transport command gives three results and a status request four, so the back stays on
// a send until its last byte is out, one result per unstalled cycle from its output register.
// Reset is asynchronous and clears the framer, the pending flag and all valid state at
// once; there is no clearing pass. A stalled result channel holds the output register
// while the front keeps accepting until the queue is full.
module deck_control_link_client (
    input  logic      clk,
    input  logic      rst_n,
    dclc_chan_if.sink   item_ch,
    dclc_chan_if.source result_ch
);
    import dclc_pkg::*;

    logic      q_push;
    logic      q_pop;
    desc_t     push_desc;
    desc_t     head_desc;
    q_status_t q_st;

    // The front classifies each request and updates the framer and link state.
    dclc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_ch (item_ch),
        .q_st    (q_st),
        .push    (q_push),
        .desc    (push_desc)
    );

    // The queue decouples classification from result generation.
    dclc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head_desc (head_desc),
        .q_st      (q_st)
    );

    // The back expands sends into their bytes and drives the output register.
    dclc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_desc (head_desc),
        .q_st      (q_st),
        .pop       (q_pop),
        .result_ch (result_ch)
    );

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_st.full)
        else $error("request pushed into a full queue");

    // The back must never pop an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_st.empty)
        else $error("request popped from an empty queue");

    // A result that carries no byte is always the only result of its request.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.payload.tx_valid) |-> result_ch.payload.tx_last)
        else $error("byte-less result not marked last");

    // Transmitted bytes only follow a send, which leaves an answer pending.
    a_send_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.payload.tx_valid) |->
            (!result_ch.payload.tx_ready && !result_ch.payload.frame_end))
        else $error("transmitted byte without pending answer");

endmodule

@@ bench/deck_control_link_client_test.sv @@
module deck_control_link_client_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dclc_pkg::*;

    // The two transport codes that carry no meaning; the block must ignore them.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Cycles allowed after the last result for anything stray to appear.
    localparam int SETTLE_CYCLES = 16;

    logic clk = 1'b0;
    logic rst_n;

    dclc_chan_if #(.payload_t(item_t))   item_ch ();
    dclc_chan_if #(.payload_t(result_t)) result_ch ();

    deck_control_link_client i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch)
    );

    always #5ns clk = ~clk;

    // Percentages of cycles in which the sender holds back a request and in which
    // the receiver refuses a result. Each test sets its own mix.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    int requests_sent = 0;
    int fail_count    = 0;

    // Results that the accepted requests are due to produce, oldest first.
    result_t due_results[$];

    // Our own copy of the link client's state. The receive framer position, the
    // position of the checksum byte and the running sum of the frame so far.
    logic [4:0]  fr_pos          = '0;
    logic [4:0]  fr_sum_pos      = '0;
    logic [7:0]  fr_sum          = '0;
    logic [7:0]  fr_bytes [FRAME_LIMIT];
    logic [7:0]  status_sum_seen = '0;
    logic [12:0] deck_flag_bits  = '0;
    logic        awaiting_answer = 1'b0;

    // Frame under construction by the stimulus, checksum not yet appended, and the
    // last status frame sent, kept so that it can be repeated unchanged.
    logic [7:0] frame_buf[$];
    logic [7:0] prev_status[$];

    // The receiver refuses results at random; with stall_pct at zero it never does.
    always @(negedge clk)
    begin
        result_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // Works out what one accepted request must produce and queues it. A received
    // byte advances the framer; a command either goes out as bytes with a trailing
    // checksum, is refused because an answer is still outstanding, or is ignored.
    function automatic void predict_link_results(input item_t req);
        result_t     r;
        logic [7:0]  frame[$];
        logic [7:0]  sum;
        logic [15:0] id;
        r         = '0;
        r.tx_last = 1'b1;
        if (req.cmd == CMD_RX)
        begin
            if (fr_pos >= FRAME_LIMIT)
            begin
                // Store overflow: drop the byte and restart the framer.
                fr_pos          = '0;
                awaiting_answer = 1'b0;
            end
            else
            begin
                fr_bytes[fr_pos] = req.rx_byte;
                if (fr_pos == 0)
                begin
                    fr_sum     = '0;
                    fr_sum_pos = 5'(req.rx_byte[3:0]) + 5'd2;
                end
                if (fr_pos == fr_sum_pos)
                begin
                    r.frame_end = 1'b1;
                    if (fr_sum == req.rx_byte)
                    begin
                        id = {fr_bytes[0], fr_bytes[1]};
                        if (id == ID_STATUS)
                        begin
                            r.reply_kind = KIND_STATUS;
                            // Flags are reloaded only when the status has changed,
                            // which the deck signals through a different checksum.
                            if (fr_sum != status_sum_seen)
                            begin
                                status_sum_seen  = fr_sum;
                                deck_flag_bits   = {fr_bytes[10][4], fr_bytes[10][5],
                                                    fr_bytes[4][1], fr_bytes[4][2],
                                                    fr_bytes[4][4], fr_bytes[2][0],
                                                    fr_bytes[2][5], fr_bytes[3][7],
                                                    fr_bytes[3][5], fr_bytes[3][3:0]};
                                r.status_updated = 1'b1;
                            end
                        end
                        else if (id == ID_ACK)
                            r.reply_kind = KIND_ACK;
                        else if (id == ID_NACK)
                        begin
                            r.reply_kind = KIND_NACK;
                            r.nack_code  = fr_bytes[2];
                        end
                        else
                            r.reply_kind = KIND_OTHER;
                    end
                    else
                        r.checksum_bad = 1'b1;
                    // Any frame end, good or bad, answers the outstanding command.
                    fr_pos          = '0;
                    awaiting_answer = 1'b0;
                end
                else
                begin
                    fr_sum = fr_sum + req.rx_byte;
                    fr_pos = fr_pos + 5'd1;
                end
            end
        end
        else if (req.transport_op == OP_STATUS)
            frame = '{STATUS_B0, STATUS_B1, STATUS_B2};
        else if (req.transport_op > OP_STATUS)
            ;
        else if (awaiting_answer)
            r.cmd_refused = 1'b1;
        else
        begin
            case (req.transport_op)
                OP_PLAY:   frame = '{TRANSPORT_HDR, CODE_PLAY};
                OP_RECORD: frame = '{TRANSPORT_HDR, CODE_RECORD};
                OP_FFWD:   frame = '{TRANSPORT_HDR, CODE_FFWD};
                OP_REWIND: frame = '{TRANSPORT_HDR, CODE_REWIND};
                default:   frame = '{TRANSPORT_HDR, CODE_STOP};
            endcase
        end

        if (frame.size() != 0)
        begin
            sum = '0;
            foreach (frame[k])
                sum = sum + frame[k];
            frame.push_back(sum);
            awaiting_answer = 1'b1;
            foreach (frame[k])
            begin
                r.tx_valid   = 1'b1;
                r.tx_byte    = frame[k];
                r.tx_last    = (k == frame.size() - 1);
                r.deck_flags = deck_flag_bits;
                r.tx_ready   = 1'b0;
                due_results.push_back(r);
            end
        end
        else
        begin
            r.deck_flags = deck_flag_bits;
            r.tx_ready   = !awaiting_answer;
            due_results.push_back(r);
        end
    endfunction

    // Every result taken by the receiver is held against the oldest one due.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.payload;
            if (due_results.size() == 0)
                report_mismatch($sformatf("result %h arrived with none due", got));
            else
            begin
                want = due_results.pop_front();
                check_field("tx_valid", got.tx_valid, want.tx_valid);
                check_field("tx_byte", got.tx_byte, want.tx_byte);
                check_field("tx_last", got.tx_last, want.tx_last);
                check_field("frame_end", got.frame_end, want.frame_end);
                check_field("checksum_bad", got.checksum_bad, want.checksum_bad);
                check_field("reply_kind", got.reply_kind, want.reply_kind);
                check_field("nack_code", got.nack_code, want.nack_code);
                check_field("deck_flags", got.deck_flags, want.deck_flags);
                check_field("status_updated", got.status_updated, want.status_updated);
                check_field("tx_ready", got.tx_ready, want.tx_ready);
                check_field("cmd_refused", got.cmd_refused, want.cmd_refused);
            end
        end
    end

    // Offers one request, after a random number of idle cycles, and returns at the
    // rising edge at which it is accepted. The valid line stays high until the
    // next falling edge, where the following call either idles or replaces it.
    task automatic send_request(input item_t req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid   = 1'b1;
        item_ch.payload = req;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predict_link_results(req);
        requests_sent++;
    endtask

    // The field that a request does not use still carries random bits.
    task automatic send_rx(input logic [7:0] value);
        item_t req;
        req.cmd          = CMD_RX;
        req.rx_byte      = value;
        req.transport_op = 3'($urandom_range(7));
        send_request(req);
    endtask

    task automatic send_cmd(input logic [2:0] op);
        item_t req;
        req.cmd          = CMD_SEND;
        req.rx_byte      = 8'($urandom);
        req.transport_op = op;
        send_request(req);
    endtask

    // Lowers valid and waits until every result due has been taken.
    task automatic hold_off_until_drained();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // Fills frame_buf with the header of a frame of the given class and random
    // content up to, but not including, the checksum byte.
    function automatic void build_frame(input int shape);
        logic [3:0] nibble;
        frame_buf.delete();
        case (shape)
            0:
            begin
                // Now and then the same status again, which must not reload the flags.
                if (prev_status.size() != 0 && $urandom_range(4) == 0)
                    frame_buf = prev_status;
                else
                    frame_buf = '{ID_STATUS[15:8], ID_STATUS[7:0]};
            end
            1: frame_buf = '{ID_ACK[15:8], ID_ACK[7:0]};
            2: frame_buf = '{ID_NACK[15:8], ID_NACK[7:0]};
            default:
            begin
                // Mostly short frames, sometimes up to the longest the header allows.
                if ($urandom_range(4) == 0)
                    nibble = 4'($urandom_range(15));
                else
                    nibble = 4'($urandom_range(3));
                frame_buf = '{{4'($urandom), nibble}, 8'($urandom)};
            end
        endcase
        while (frame_buf.size() < int'(frame_buf[0][3:0]) + 2)
            frame_buf.push_back(8'($urandom));
        if (shape == 0)
            prev_status = frame_buf;
    endfunction

    // Sends frame_buf with its checksum, spoilt if asked, and with commands slipped
    // in between the bytes now and then. Stray bytes first bring the framer back
    // to the start of a frame so that the frame lines up.
    task automatic send_frame(input bit corrupt, input int mix_pct);
        logic [7:0] sum;
        while (fr_pos != 0)
            send_rx(8'($urandom));
        sum = '0;
        foreach (frame_buf[k])
            sum = sum + frame_buf[k];
        if (corrupt)
            sum = sum ^ 8'($urandom_range(255, 1));
        frame_buf.push_back(sum);
        foreach (frame_buf[k])
        begin
            if ($urandom_range(99) < mix_pct)
                send_cmd(3'($urandom_range(7)));
            send_rx(frame_buf[k]);
        end
    endtask

    // Random traffic: mostly well formed frames of every class, a share of them
    // with a bad checksum, commands of every code, and loose noise bytes.
    task automatic run_random_traffic(input int n_requests);
        int stop_at;
        int pick;
        stop_at = requests_sent + n_requests;
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                build_frame($urandom_range(3));
                send_frame(pick < 8, 15);
            end
            else if (pick < 80)
                send_cmd(3'($urandom_range(5)));
            else if (pick < 85)
                send_cmd(3'($urandom_range(7, 6)));
            else
                send_rx(8'($urandom));
        end
    endtask

    // A short fixed sequence: the spare codes, every transport command accepted,
    // rewind and record also refused, a status request while an answer is outstanding,
    // commands in the middle of a frame, a NACK, a bad checksum and byte extremes.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_cmd(OP_SPARE_LO);
        send_cmd(OP_SPARE_HI);
        send_cmd(OP_PLAY);
        send_cmd(OP_RECORD);
        send_cmd(OP_STATUS);
        build_frame(1);
        send_frame(1'b0, 0);
        send_cmd(OP_FFWD);
        // A NACK with a refused rewind and a status request inside it.
        send_rx(ID_NACK[15:8]);
        send_cmd(OP_REWIND);
        send_rx(ID_NACK[7:0]);
        send_cmd(OP_STATUS);
        send_rx(8'hFF);
        send_rx(8'(ID_NACK[15:8] + ID_NACK[7:0] + 8'hFF));
        send_cmd(OP_STOP);
        // Zero header, all-ones content and a checksum that does not match.
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(8'h00);
        send_cmd(OP_REWIND);
        send_cmd(OP_RECORD);
        build_frame(1);
        send_frame(1'b0, 0);
        send_cmd(OP_RECORD);
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random_traffic(60);
    endtask

    // The sender also stops once half way and lets every result drain.
    task automatic test_sender_gaps();
        send_idle_pct = 69;
        stall_pct     = 0;
        run_random_traffic(30);
        hold_off_until_drained();
        run_random_traffic(30);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        stall_pct     = 69;
        run_random_traffic(60);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 24;
        stall_pct     = 24;
        run_random_traffic(60);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.payload   = '0;
        result_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        hold_off_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // A healthy run ends long before this watchdog fires.
    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
